// ===== design/kpbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbs_pkg: shared types and constants
// Operation codes, word layout and the KISS99 start and step constants.
// ----------------------------------------------------------------------------
package kpbs_pkg;

   // Operation codes carried on the request tuser
   localparam logic [1:0] OP_RELOAD   = 2'd0;
   localparam logic [1:0] OP_SEED     = 2'd1;
   localparam logic [1:0] OP_GENERATE = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 3;
   localparam int unsigned TDATA_W = 40;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

   // Start values of the four generator words
   localparam logic [WORD_W-1:0] START_MWC_HIGH = 32'd362436069;
   localparam logic [WORD_W-1:0] START_MWC_LOW  = 32'd521288629;
   localparam logic [WORD_W-1:0] START_XORSHIFT = 32'd123456789;
   localparam logic [WORD_W-1:0] START_CONG     = 32'd380116160;

   // Step constants
   localparam logic [15:0]       MWC_HIGH_MULT = 16'd36969;
   localparam logic [15:0]       MWC_LOW_MULT  = 16'd18000;
   localparam logic [WORD_W-1:0] CONG_MULT     = 32'd69069;
   localparam logic [WORD_W-1:0] CONG_INC      = 32'd1234567;

   typedef struct packed {
      logic [1:0]         op;
      logic [WORD_W-1:0]  seed_group;
      logic [COUNT_W-1:0] byte_count;
   } item_type;

   typedef struct packed {
      logic [WORD_W-1:0] mwc_high;
      logic [WORD_W-1:0] mwc_low;
      logic [WORD_W-1:0] xorshift_word;
      logic [WORD_W-1:0] congruential_word;
   } gen_state_type;

   localparam gen_state_type START_STATE = '{
      mwc_high:          START_MWC_HIGH,
      mwc_low:           START_MWC_LOW,
      xorshift_word:     START_XORSHIFT,
      congruential_word: START_CONG
   };

   typedef struct packed {
      logic               emit;
      logic [WORD_W-1:0]  random_word;
      logic [COUNT_W-1:0] valid_bytes;
   } step_result_type;

endpackage

// ===== design/kpbs_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbs_in_stage: request input register
// Captures one request word and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module kpbs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // seed_group [31:0], byte_count [34:32], zero fill [39:35]
   input  logic [kpbs_pkg::TDATA_W-1:0] req_tdata,
   // op [1:0]
   input  logic [1:0]            req_tuser,
   input  logic                  take,
   output logic                  item_valid,
   output kpbs_pkg::item_type    item
);

   logic               valid_ff;
   logic               valid_in;
   kpbs_pkg::item_type item_ff;
   kpbs_pkg::item_type item_in;
   logic               accept;

   // Take a new word whenever the held one leaves in this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.op         = req_tuser;
         item_in.seed_group = req_tdata[31:0];
         item_in.byte_count = req_tdata[34:32];
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/kpbs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbs_step: KISS99 step and seed logic
// Works out the next generator state and the result for one request.
// ----------------------------------------------------------------------------
module kpbs_step (
   input  kpbs_pkg::gen_state_type   state,
   input  kpbs_pkg::item_type        item,
   output kpbs_pkg::gen_state_type   next_state,
   output kpbs_pkg::step_result_type result
);

   logic [kpbs_pkg::COUNT_W-1:0] count_sat;
   kpbs_pkg::gen_state_type      seeded;
   kpbs_pkg::gen_state_type      adv_src;
   kpbs_pkg::gen_state_type      adv;
   logic [kpbs_pkg::WORD_W-1:0]  hi_prod;
   logic [kpbs_pkg::WORD_W-1:0]  lo_prod;
   logic [kpbs_pkg::WORD_W-1:0]  xs_a;
   logic [kpbs_pkg::WORD_W-1:0]  xs_b;
   logic [kpbs_pkg::WORD_W-1:0]  mix;
   logic [kpbs_pkg::WORD_W-1:0]  kiss_word;

   // Clamp oversized counts to a full group
   assign count_sat = (item.byte_count > kpbs_pkg::COUNT_FULL) ?
                      kpbs_pkg::COUNT_FULL : item.byte_count;

   // Fold seed bytes into the words, lowest byte first
   always_comb begin
      seeded = state;
      if (count_sat >= 3'd1) begin
         seeded.mwc_high = state.mwc_high ^ {24'd0, item.seed_group[7:0]};
      end
      if (count_sat >= 3'd2) begin
         seeded.mwc_low = state.mwc_low ^ {24'd0, item.seed_group[15:8]};
      end
      if (count_sat >= 3'd3) begin
         seeded.xorshift_word = state.xorshift_word ^ {24'd0, item.seed_group[23:16]};
      end
      if (count_sat == kpbs_pkg::COUNT_FULL) begin
         seeded.congruential_word = state.congruential_word ^
                                    {24'd0, item.seed_group[31:24]};
      end
   end

   assign adv_src = (item.op == kpbs_pkg::OP_SEED) ? seeded : state;

   // One generator step: two MWC halves, xorshift, congruential
   assign hi_prod = {16'd0, adv_src.mwc_high[15:0]} * {16'd0, kpbs_pkg::MWC_HIGH_MULT};
   assign lo_prod = {16'd0, adv_src.mwc_low[15:0]} * {16'd0, kpbs_pkg::MWC_LOW_MULT};
   assign adv.mwc_high = hi_prod + {16'd0, adv_src.mwc_high[31:16]};
   assign adv.mwc_low  = lo_prod + {16'd0, adv_src.mwc_low[31:16]};

   assign xs_a = adv_src.xorshift_word ^ (adv_src.xorshift_word << 17);
   assign xs_b = xs_a ^ (xs_a >> 13);
   assign adv.xorshift_word = xs_b ^ (xs_b << 5);

   assign adv.congruential_word = adv_src.congruential_word * kpbs_pkg::CONG_MULT +
                                  kpbs_pkg::CONG_INC;

   assign mix       = {adv.mwc_high[15:0], 16'd0} + adv.mwc_low;
   assign kiss_word = (mix ^ adv.congruential_word) + adv.xorshift_word;

   always_comb begin
      next_state         = state;
      result.emit        = 1'b0;
      result.random_word = kiss_word;
      result.valid_bytes = count_sat;
      unique case (item.op)
         kpbs_pkg::OP_RELOAD: begin
            next_state = kpbs_pkg::START_STATE;
         end
         kpbs_pkg::OP_SEED: begin
            next_state = (count_sat == kpbs_pkg::COUNT_FULL) ? adv : seeded;
         end
         kpbs_pkg::OP_GENERATE: begin
            if (count_sat != kpbs_pkg::COUNT_NONE) begin
               next_state  = adv;
               result.emit = 1'b1;
            end
         end
         kpbs_pkg::OP_UNUSED: begin
            next_state = state;
         end
      endcase
   end

endmodule

// ===== design/kiss_prng_with_byte_seeding_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_prng_with_byte_seeding_core: KISS99 generator with byte seeding
// Reloads start constants, absorbs seed bytes and generates 32-bit words.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                                 | tuser
//  ---------+-----------+---------------------------------------+---------
//  req_     | in        | seed_group[31:0], byte_count[34:32]   | op[1:0]
//  rsp_     | out       | random_word[31:0], valid_bytes[34:32] | -
//
//  A request word is held in the input register; the step logic
//  then updates the four generator words and loads the result register,
//  which drives rsp_tvalid; one request per cycle is sustained while
//  rsp_tready keeps the result register from stalling.
//  The combinational state update (three multipliers and the KISS mix)
//  closes the loop between requests.
//  Reset loads the start constants and empties both registers.
//  A stalled result holds only generate requests; reload and seed requests
//  keep flowing while a result waits.
//
module kiss_prng_with_byte_seeding_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // seed_group [31:0], byte_count [34:32], zero fill [39:35]
   input  logic [39:0] req_tdata,
   // op [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // random_word [31:0], valid_bytes [34:32], zero fill [39:35]
   output logic [39:0] rsp_tdata
);

   logic                      item_valid;
   kpbs_pkg::item_type        item;
   logic                      take;
   logic                      out_free;
   kpbs_pkg::gen_state_type   state_ff;
   kpbs_pkg::gen_state_type   state_in;
   kpbs_pkg::gen_state_type   step_state;
   kpbs_pkg::step_result_type step_res;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [kpbs_pkg::WORD_W-1:0]         rsp_word_ff;
   logic [kpbs_pkg::WORD_W-1:0]         rsp_word_in;
   logic [kpbs_pkg::COUNT_W-1:0]        rsp_bytes_ff;
   logic [kpbs_pkg::COUNT_W-1:0]        rsp_bytes_in;

   kpbs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   kpbs_step u_step (
      .state      (state_ff),
      .item       (item),
      .next_state (step_state),
      .result     (step_res)
   );

   // The result register frees up when empty or drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Hold a generate request while its result has nowhere to go
   assign take = item_valid && (!step_res.emit || out_free);

   // Advance the generator only on a taken request
   assign state_in = take ? step_state : state_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      if (take && step_res.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = step_res.random_word;
         rsp_bytes_in = step_res.valid_bytes;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpbs_pkg::START_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_bytes_ff, rsp_word_ff};

`ifndef ASSERT_OFF
   // Reset lands on the start constants with no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> (state_ff == kpbs_pkg::START_STATE) && !rsp_valid_ff)
      else $error("generator not at start state after reset");

   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && step_res.emit) |-> !take)
      else $error("pending result overwritten");

   // A taken generate request shows up as a result next cycle
   a_emit_visible: assert property (@(posedge clock) disable iff (reset)
      (take && step_res.emit) |=> rsp_valid_ff)
      else $error("generated word lost");

   // Reload brings back the start constants
   a_reload: assert property (@(posedge clock) disable iff (reset)
      (take && item.op == kpbs_pkg::OP_RELOAD) |=> (state_ff == kpbs_pkg::START_STATE))
      else $error("reload did not restore start state");

   // A pending result always carries a byte count of one to four
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_bytes_ff != kpbs_pkg::COUNT_NONE) &&
                       (rsp_bytes_ff <= kpbs_pkg::COUNT_FULL))
      else $error("result byte count out of range");
`endif

endmodule
